FILE: rtl/crir_pkg.sv
`timescale 1ns / 1ps
package crir_pkg;

	localparam int BODY_COUNT = 64;
	localparam int ADDR_W = $clog2(BODY_COUNT);
	localparam int IDX_W = 6;
	localparam int COEF_W = 17;
	localparam int Q_FRAC = 16;
	// magnitude of n * 2^16 with n up to 2^31
	localparam int DIV_BITS = 32 + Q_FRAC;
	localparam logic signed [31:0] ONE_Q = 32'sd65536;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_RESOLVE = 2'd1,
		OP_READ    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	// one body entry as held in the table
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] ang;
		logic signed [31:0] im;
		logic signed [31:0] ii;
		logic [COEF_W-1:0]  rest;
		logic [COEF_W-1:0]  fric;
	} body_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] wa, wb;
		wa = 64'(a);
		wb = 64'(b);
		return sat32(wa + wb);
	endfunction

	function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] wa, wb;
		wa = 64'(a);
		wb = 64'(b);
		return sat32(wa - wb);
	endfunction

	function automatic logic signed [31:0] qneg(input logic signed [31:0] a);
		logic signed [63:0] wa;
		wa = 64'(a);
		return sat32(-wa);
	endfunction

	// exact product, floor shift by the fraction width, saturate
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] wa, wb, p;
		wa = 64'(a);
		wb = 64'(b);
		p = wa * wb;
		return sat32(p >>> Q_FRAC);
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] a);
		logic [31:0] r;
		r = a[31] ? 32'(-a) : 32'(a);
		return r;
	endfunction

endpackage

FILE: rtl/contact_impulse_resolver_unit.sv
`timescale 1ns / 1ps
// Contact impulse resolver: a table of 64 rigid bodies (Q16.16) with a
// resolver for contacts between two of them.
// Input channel (in_valid/in_ready) carries one command item: write a body,
// read a body, or resolve a contact. Output channel (out_valid/out_ready)
// carries body reports; last marks the final report of a command.
// One item is worked on at a time; in_ready is high only when idle.
// Write: stored in the table on acceptance, no report. Read: the body is
// read from the table and sent as one report. Resolve: both bodies are
// read, updated, written back and reported, body A first, then body B.
// The work is four divisions on the one shared divider plus
// single-multiply and bookkeeping steps. A skipped contact (both bodies
// static, or a summed inverse mass of zero) reports both bodies
// unchanged and does not write them back.
// The body table sits in a synchronous RAM read back into working
// registers, updated there and written back before reporting.
// Reset clears the control state only; the table is undefined until each
// entry is written. A stalled receiver holds the report in the output
// register; the next command is taken once the last report is loaded.
module contact_impulse_resolver_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [5:0]          first_index,
	input  logic [5:0]          second_index,
	input  logic signed [31:0]  vec_one_x,
	input  logic signed [31:0]  vec_one_y,
	input  logic signed [31:0]  vec_two_x,
	input  logic signed [31:0]  vec_two_y,
	input  logic signed [31:0]  vec_three_x,
	input  logic signed [31:0]  vec_three_y,
	input  logic signed [31:0]  scalar_one,
	input  logic [16:0]         scalar_two,
	input  logic [16:0]         scalar_three,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [5:0]          body_index,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [31:0]  vel_x,
	output logic signed [31:0]  vel_y,
	output logic signed [31:0]  ang_vel,
	output logic                last
);

	typedef enum logic [5:0] {
		S_IDLE, S_RD_A, S_RD_B, S_CAP_B, S_TOT, S_CHK, S_DIV_CA, S_MUL_CB,
		S_DIV_CB, S_PAX, S_PAY, S_PBX, S_PBY, S_ARM, S_VAX, S_VAY, S_VBX,
		S_VBY, S_RV, S_D0, S_D1, S_D2, S_C1A, S_C1B, S_C2A, S_C2B, S_Q1A,
		S_Q1B, S_Q2A, S_Q2B, S_DIV_J, S_JXA, S_JXB, S_JYA, S_JYB, S_AVX,
		S_AVY, S_AWA, S_AWB, S_AWC, S_NEG, S_BVX, S_BVY, S_BWA, S_BWB,
		S_BWC, S_WR_A, S_WR_B, S_EMIT_A, S_EMIT_B
	} state_t;

	state_t state_q;

	// latched command
	crir_pkg::op_t                op_q;
	logic [crir_pkg::ADDR_W-1:0]  ia_q, ib_q;
	logic signed [31:0]           sx_q, sy_q, ex_q, ey_q, nx_q, ny_q, depth_q;

	// working copies of both bodies
	crir_pkg::body_t ent_a_q, ent_b_q;

	// intermediates
	logic signed [31:0] t_q, u_q, c1_q, c2_q, den_q, tot_q, ca_q, cb_q;
	logic signed [31:0] rax_q, ray_q, rbx_q, rby_q, vax_q, vay_q, vbx_q, vby_q;
	logic signed [31:0] rvx_q, rvy_q, vd_q, jn_q, jt_q, jx_q, jy_q;
	logic signed [31:0] dx_q, dy_q, tx_q, ty_q;
	logic [crir_pkg::COEF_W-1:0] e_q, f_q;
	logic phase_q;
	logic div_run_q;

	logic                out_valid_q;
	logic [5:0]          out_idx_q;
	logic signed [31:0]  out_px_q, out_py_q, out_vx_q, out_vy_q, out_w_q;
	logic                out_last_q;

	logic               acc_in;
	logic               same;
	logic               out_free;
	logic               emit_now;
	logic signed [31:0] ma, mb, prod, res;
	logic signed [31:0] e_ext, f_ext;

	logic                        ram_we;
	logic [crir_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
	crir_pkg::body_t             ram_wdata, ram_rdata;

	logic               div_start, div_done, div_state;
	logic signed [31:0] div_den, div_quo;

	assign in_ready = state_q == S_IDLE;
	assign acc_in = in_valid && in_ready;
	assign same = ia_q == ib_q;
	assign out_free = !out_valid_q || out_ready;
	assign emit_now = (state_q == S_EMIT_A || state_q == S_EMIT_B) && out_free;
	assign e_ext = $signed({15'b0, e_q});
	assign f_ext = $signed({15'b0, f_q});

	// body table
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = crir_pkg::ADDR_W'(first_index % crir_pkg::BODY_COUNT);
		ram_wdata = '{vec_one_x, vec_one_y, vec_two_x, vec_two_y, vec_three_x,
			vec_three_y, scalar_one, scalar_two, scalar_three};
		if (acc_in && crir_pkg::op_t'(op) == crir_pkg::OP_WRITE) ram_we = 1'b1;
		if (state_q == S_WR_A) begin
			ram_we = 1'b1;
			ram_waddr = ia_q;
			ram_wdata = ent_a_q;
		end else if (state_q == S_WR_B) begin
			ram_we = 1'b1;
			ram_waddr = ib_q;
			ram_wdata = ent_b_q;
		end
	end

	assign ram_raddr = (state_q == S_RD_B) ? ib_q : ia_q;

	crir_ram #(
		.WIDTH($bits(crir_pkg::body_t)),
		.DEPTH(crir_pkg::BODY_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared divider
	assign div_state = state_q == S_DIV_CA || state_q == S_DIV_CB || state_q == S_DIV_J;
	assign div_start = div_state && !div_run_q;
	assign div_den = (state_q == S_DIV_J) ? den_q : tot_q;

	crir_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (t_q),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// shared multiplier and the add that follows it
	always_comb begin
		ma = 32'sd0;
		mb = 32'sd0;
		unique case (state_q)
			S_CHK:    begin ma = depth_q;   mb = ent_a_q.im; end
			S_MUL_CB: begin ma = depth_q;   mb = ent_b_q.im; end
			S_PAX:    begin ma = nx_q;      mb = ca_q; end
			S_PAY:    begin ma = ny_q;      mb = ca_q; end
			S_PBX:    begin ma = nx_q;      mb = cb_q; end
			S_PBY:    begin ma = ny_q;      mb = cb_q; end
			S_VAX:    begin ma = ent_a_q.ang; mb = ray_q; end
			S_VAY:    begin ma = ent_a_q.ang; mb = rax_q; end
			S_VBX:    begin ma = ent_b_q.ang; mb = rby_q; end
			S_VBY:    begin ma = ent_b_q.ang; mb = rbx_q; end
			S_D0:     begin ma = rvx_q;     mb = dx_q; end
			S_D1:     begin ma = rvy_q;     mb = dy_q; end
			S_D2: begin
				if (phase_q) begin
					ma = f_ext;
					mb = crir_pkg::qneg(vd_q);
				end else begin
					ma = crir_pkg::qneg(crir_pkg::qadd(crir_pkg::ONE_Q, e_ext));
					mb = vd_q;
				end
			end
			S_C1A:    begin ma = rax_q;     mb = dy_q; end
			S_C1B:    begin ma = ray_q;     mb = dx_q; end
			S_C2A:    begin ma = rbx_q;     mb = dy_q; end
			S_C2B:    begin ma = rby_q;     mb = dx_q; end
			S_Q1A:    begin ma = c1_q;      mb = c1_q; end
			S_Q1B:    begin ma = u_q;       mb = ent_a_q.ii; end
			S_Q2A:    begin ma = c2_q;      mb = c2_q; end
			S_Q2B:    begin ma = u_q;       mb = ent_b_q.ii; end
			S_JXA:    begin ma = nx_q;      mb = jn_q; end
			S_JXB:    begin ma = tx_q;      mb = jt_q; end
			S_JYA:    begin ma = ny_q;      mb = jn_q; end
			S_JYB:    begin ma = ty_q;      mb = jt_q; end
			S_AVX:    begin ma = jx_q;      mb = ent_a_q.im; end
			S_AVY:    begin ma = jy_q;      mb = ent_a_q.im; end
			S_AWA:    begin ma = rax_q;     mb = jy_q; end
			S_AWB:    begin ma = ray_q;     mb = jx_q; end
			S_AWC:    begin ma = c1_q;      mb = ent_a_q.ii; end
			S_BVX:    begin ma = jx_q;      mb = ent_b_q.im; end
			S_BVY:    begin ma = jy_q;      mb = ent_b_q.im; end
			S_BWA:    begin ma = rbx_q;     mb = jy_q; end
			S_BWB:    begin ma = rby_q;     mb = jx_q; end
			S_BWC:    begin ma = c1_q;      mb = ent_b_q.ii; end
			default:  begin ma = 32'sd0;    mb = 32'sd0; end
		endcase
	end

	assign prod = crir_pkg::qmul(ma, mb);

	always_comb begin
		unique case (state_q)
			S_PAX:   res = crir_pkg::qsub(ent_a_q.pos_x, prod);
			S_PAY:   res = crir_pkg::qsub(ent_a_q.pos_y, prod);
			S_PBX:   res = crir_pkg::qadd(ent_b_q.pos_x, prod);
			S_PBY:   res = crir_pkg::qadd(ent_b_q.pos_y, prod);
			S_VAX:   res = crir_pkg::qadd(ent_a_q.vel_x, crir_pkg::qneg(prod));
			S_VAY:   res = crir_pkg::qadd(ent_a_q.vel_y, prod);
			S_VBX:   res = crir_pkg::qadd(ent_b_q.vel_x, crir_pkg::qneg(prod));
			S_VBY:   res = crir_pkg::qadd(ent_b_q.vel_y, prod);
			S_D1:    res = crir_pkg::qadd(t_q, prod);
			S_C1B, S_C2B, S_AWB, S_BWB: res = crir_pkg::qsub(u_q, prod);
			S_Q1B:   res = crir_pkg::qadd(tot_q, prod);
			S_Q2B:   res = crir_pkg::qadd(den_q, prod);
			S_JXB, S_JYB: res = crir_pkg::qadd(t_q, prod);
			S_AVX:   res = crir_pkg::qadd(ent_a_q.vel_x, prod);
			S_AVY:   res = crir_pkg::qadd(ent_a_q.vel_y, prod);
			S_AWC:   res = crir_pkg::qadd(ent_a_q.ang, prod);
			S_BVX:   res = crir_pkg::qadd(ent_b_q.vel_x, prod);
			S_BVY:   res = crir_pkg::qadd(ent_b_q.vel_y, prod);
			S_BWC:   res = crir_pkg::qadd(ent_b_q.ang, prod);
			default: res = prod;
		endcase
	end

	// sequencer; writes to one body mirror into the other when A equals B
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_run_q   <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (emit_now) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						op_q    <= crir_pkg::op_t'(op);
						ia_q    <= crir_pkg::ADDR_W'(first_index % crir_pkg::BODY_COUNT);
						ib_q    <= crir_pkg::ADDR_W'(second_index % crir_pkg::BODY_COUNT);
						sx_q    <= vec_one_x;
						sy_q    <= vec_one_y;
						ex_q    <= vec_two_x;
						ey_q    <= vec_two_y;
						nx_q    <= vec_three_x;
						ny_q    <= vec_three_y;
						depth_q <= scalar_one;
						phase_q <= 1'b0;
						if (crir_pkg::op_t'(op) == crir_pkg::OP_RESOLVE ||
							crir_pkg::op_t'(op) == crir_pkg::OP_READ) begin
							state_q <= S_RD_A;
						end
					end
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: begin
					ent_a_q <= ram_rdata;
					state_q <= (op_q == crir_pkg::OP_READ) ? S_EMIT_A : S_CAP_B;
				end
				S_CAP_B: begin
					ent_b_q <= ram_rdata;
					state_q <= S_TOT;
				end
				S_TOT: begin
					tot_q <= crir_pkg::qadd(ent_a_q.im, ent_b_q.im);
					if (ent_a_q.im == 32'sd0 && ent_b_q.im == 32'sd0) state_q <= S_EMIT_A;
					else state_q <= S_CHK;
				end
				S_CHK: begin
					t_q <= res;
					state_q <= (tot_q == 32'sd0) ? S_EMIT_A : S_DIV_CA;
				end
				S_DIV_CA, S_DIV_CB, S_DIV_J: begin
					if (!div_run_q) div_run_q <= 1'b1;
					else if (div_done) begin
						div_run_q <= 1'b0;
						if (state_q == S_DIV_CA) begin
							ca_q <= div_quo;
							state_q <= S_MUL_CB;
						end else if (state_q == S_DIV_CB) begin
							cb_q <= div_quo;
							state_q <= S_PAX;
						end else if (!phase_q) begin
							jn_q <= div_quo;
							dx_q <= tx_q;
							dy_q <= ty_q;
							phase_q <= 1'b1;
							state_q <= S_D0;
						end else begin
							jt_q <= div_quo;
							state_q <= S_JXA;
						end
					end
				end
				S_MUL_CB: begin t_q <= res; state_q <= S_DIV_CB; end
				S_PAX: begin
					ent_a_q.pos_x <= res;
					if (same) ent_b_q.pos_x <= res;
					state_q <= S_PAY;
				end
				S_PAY: begin
					ent_a_q.pos_y <= res;
					if (same) ent_b_q.pos_y <= res;
					state_q <= S_PBX;
				end
				S_PBX: begin
					ent_b_q.pos_x <= res;
					if (same) ent_a_q.pos_x <= res;
					state_q <= S_PBY;
				end
				S_PBY: begin
					ent_b_q.pos_y <= res;
					if (same) ent_a_q.pos_y <= res;
					state_q <= S_ARM;
				end
				// lever arms, coefficients and tangent
				S_ARM: begin
					rax_q <= crir_pkg::qsub(ex_q, ent_a_q.pos_x);
					ray_q <= crir_pkg::qsub(ey_q, ent_a_q.pos_y);
					rbx_q <= crir_pkg::qsub(sx_q, ent_b_q.pos_x);
					rby_q <= crir_pkg::qsub(sy_q, ent_b_q.pos_y);
					e_q <= (ent_a_q.rest < ent_b_q.rest) ? ent_a_q.rest : ent_b_q.rest;
					f_q <= (ent_a_q.fric < ent_b_q.fric) ? ent_a_q.fric : ent_b_q.fric;
					tx_q <= ny_q;
					ty_q <= crir_pkg::qneg(nx_q);
					dx_q <= nx_q;
					dy_q <= ny_q;
					state_q <= S_VAX;
				end
				S_VAX: begin vax_q <= res; state_q <= S_VAY; end
				S_VAY: begin vay_q <= res; state_q <= S_VBX; end
				S_VBX: begin vbx_q <= res; state_q <= S_VBY; end
				S_VBY: begin vby_q <= res; state_q <= S_RV; end
				S_RV: begin
					rvx_q <= crir_pkg::qsub(vax_q, vbx_q);
					rvy_q <= crir_pkg::qsub(vay_q, vby_q);
					state_q <= S_D0;
				end
				// impulse along the current direction (normal, then tangent)
				S_D0:  begin t_q <= res;   state_q <= S_D1; end
				S_D1:  begin vd_q <= res;  state_q <= S_D2; end
				S_D2:  begin t_q <= res;   state_q <= S_C1A; end
				S_C1A: begin u_q <= res;   state_q <= S_C1B; end
				S_C1B: begin c1_q <= res;  state_q <= S_C2A; end
				S_C2A: begin u_q <= res;   state_q <= S_C2B; end
				S_C2B: begin c2_q <= res;  state_q <= S_Q1A; end
				S_Q1A: begin u_q <= res;   state_q <= S_Q1B; end
				S_Q1B: begin den_q <= res; state_q <= S_Q2A; end
				S_Q2A: begin u_q <= res;   state_q <= S_Q2B; end
				S_Q2B: begin den_q <= res; state_q <= S_DIV_J; end
				S_JXA: begin t_q <= res;   state_q <= S_JXB; end
				S_JXB: begin jx_q <= res;  state_q <= S_JYA; end
				S_JYA: begin t_q <= res;   state_q <= S_JYB; end
				S_JYB: begin jy_q <= res;  state_q <= S_AVX; end
				// apply to A
				S_AVX: begin
					ent_a_q.vel_x <= res;
					if (same) ent_b_q.vel_x <= res;
					state_q <= S_AVY;
				end
				S_AVY: begin
					ent_a_q.vel_y <= res;
					if (same) ent_b_q.vel_y <= res;
					state_q <= S_AWA;
				end
				S_AWA: begin u_q <= res;  state_q <= S_AWB; end
				S_AWB: begin c1_q <= res; state_q <= S_AWC; end
				S_AWC: begin
					ent_a_q.ang <= res;
					if (same) ent_b_q.ang <= res;
					state_q <= S_NEG;
				end
				S_NEG: begin
					jx_q <= crir_pkg::qneg(jx_q);
					jy_q <= crir_pkg::qneg(jy_q);
					state_q <= S_BVX;
				end
				// apply the opposite impulse to B
				S_BVX: begin
					ent_b_q.vel_x <= res;
					if (same) ent_a_q.vel_x <= res;
					state_q <= S_BVY;
				end
				S_BVY: begin
					ent_b_q.vel_y <= res;
					if (same) ent_a_q.vel_y <= res;
					state_q <= S_BWA;
				end
				S_BWA: begin u_q <= res;  state_q <= S_BWB; end
				S_BWB: begin c1_q <= res; state_q <= S_BWC; end
				S_BWC: begin
					ent_b_q.ang <= res;
					if (same) ent_a_q.ang <= res;
					state_q <= S_WR_A;
				end
				S_WR_A: state_q <= S_WR_B;
				S_WR_B: state_q <= S_EMIT_A;
				// reports
				S_EMIT_A: begin
					if (out_free) begin
						out_idx_q   <= crir_pkg::IDX_W'(ia_q);
						out_px_q    <= ent_a_q.pos_x;
						out_py_q    <= ent_a_q.pos_y;
						out_vx_q    <= ent_a_q.vel_x;
						out_vy_q    <= ent_a_q.vel_y;
						out_w_q     <= ent_a_q.ang;
						out_last_q  <= op_q == crir_pkg::OP_READ;
						state_q     <= (op_q == crir_pkg::OP_READ) ? S_IDLE : S_EMIT_B;
					end
				end
				S_EMIT_B: begin
					if (out_free) begin
						out_idx_q   <= crir_pkg::IDX_W'(ib_q);
						out_px_q    <= ent_b_q.pos_x;
						out_py_q    <= ent_b_q.pos_y;
						out_vx_q    <= ent_b_q.vel_x;
						out_vy_q    <= ent_b_q.vel_y;
						out_w_q     <= ent_b_q.ang;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign body_index = out_idx_q;
	assign pos_x      = out_px_q;
	assign pos_y      = out_py_q;
	assign vel_x      = out_vx_q;
	assign vel_y      = out_vy_q;
	assign ang_vel    = out_w_q;
	assign last       = out_last_q;

`ifndef NO_ASSERTIONS
	a_idle_no_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !div_run_q) else $error("divider running while idle");
	a_div_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_state) else $error("division finished outside a division step");
	a_table_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_IDLE || state_q == S_WR_A || state_q == S_WR_B))
		else $error("table written outside write steps");
	a_emit_b_after_a: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_B && $changed(state_q)) |-> $past(state_q == S_EMIT_A))
		else $error("second report without the first");
`endif

endmodule

FILE: rtl/crir_ram.sv
`timescale 1ns / 1ps
module crir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/crir_div.sv
`timescale 1ns / 1ps
module crir_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int CNT_W = $clog2(crir_pkg::DIV_BITS);

	logic                           busy_q;
	logic                           done_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [crir_pkg::DIV_BITS-1:0]  acc_q;
	logic [31:0]                    rem_q;
	logic [31:0]                    dmag_q;
	logic                           neg_q;
	logic                           zero_q;
	logic [32:0]                    rem_sh;
	logic                           fits;

	// restoring divide, one quotient bit a cycle
	assign rem_sh = {rem_q, acc_q[crir_pkg::DIV_BITS-1]};
	assign fits = rem_sh >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(crir_pkg::DIV_BITS - 1);
				acc_q  <= {crir_pkg::mag32(num), crir_pkg::Q_FRAC'(0)};
				rem_q  <= '0;
				dmag_q <= crir_pkg::mag32(den);
				neg_q  <= num[31] ^ den[31];
				zero_q <= den == 32'sd0;
			end else if (busy_q) begin
				// remainder stays below the divisor, so 32 bits hold it
				rem_q <= fits ? 32'(rem_sh - {1'b0, dmag_q}) : rem_sh[31:0];
				acc_q <= {acc_q[crir_pkg::DIV_BITS-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// sign and saturate the magnitude quotient; a zero divisor gives zero
	always_comb begin
		if (zero_q) quo = 32'sd0;
		else if (!neg_q) begin
			if (acc_q > crir_pkg::DIV_BITS'(32'h7fffffff)) quo = 32'sh7fffffff;
			else quo = acc_q[31:0];
		end else begin
			if (acc_q > crir_pkg::DIV_BITS'(33'h080000000)) quo = 32'sh80000000;
			else quo = -acc_q[31:0];
		end
	end

	assign done = done_q;

`ifndef NO_ASSERTIONS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");
	a_busy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == '0 && !start) |=> (!busy_q && done_q))
		else $error("divider did not finish");
`endif

endmodule

FILE: bench/tb_contact_impulse_resolver_unit.sv
`timescale 1ns / 1ps
module tb_contact_impulse_resolver_unit;

	typedef logic signed [31:0] q_t;

	localparam q_t ONE_Q = crir_pkg::ONE_Q;

	// one report as it leaves the block
	typedef struct {
		logic [5:0] idx;
		q_t px, py, vx, vy, av;
		logic lst;
	} report_t;

	// one command row
	typedef struct {
		crir_pkg::op_t op;
		logic [5:0] ia, ib;
		q_t v1x, v1y, v2x, v2y, v3x, v3y, s1;
		logic [16:0] s2, s3;
	} cmd_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, last;
	logic [1:0] op;
	logic [5:0] first_index, second_index, body_index;
	q_t vec_one_x, vec_one_y, vec_two_x, vec_two_y, vec_three_x, vec_three_y, scalar_one;
	logic [16:0] scalar_two, scalar_three;
	q_t pos_x, pos_y, vel_x, vel_y, ang_vel;

	contact_impulse_resolver_unit dut (.*);

	// predictor copy of the body table
	q_t m_px[64], m_py[64], m_vx[64], m_vy[64], m_av[64], m_im[64], m_ii[64];
	logic [16:0] m_re[64], m_fr[64];
	bit written[64];

	report_t pending_reports[$];
	int errors = 0;
	bit hold_off = 0;
	bit no_idle = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60000000;
		$display("tb_contact_impulse_resolver_unit: errors");
		$finish;
	end

	function automatic q_t s32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
	function automatic q_t fadd(q_t a, q_t b);
		return s32(64'(a) + 64'(b));
	endfunction
	function automatic q_t fsub(q_t a, q_t b);
		return s32(64'(a) - 64'(b));
	endfunction
	function automatic q_t fneg(q_t a);
		return s32(-64'(a));
	endfunction
	function automatic q_t fmul(q_t a, q_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return s32(p >>> 16);
	endfunction
	function automatic q_t fdiv(q_t n, q_t d);
		logic signed [63:0] t;
		if (d == 0) return 0;
		t = (64'(n) * 64'sd65536) / 64'(d);
		return s32(t);
	endfunction
	function automatic q_t fcross(q_t ax, q_t ay, q_t bx, q_t by);
		return fsub(fmul(ax, by), fmul(ay, bx));
	endfunction
	function automatic q_t eff_mass(q_t tot, q_t rax, q_t ray, q_t rbx, q_t rby,
		q_t dx, q_t dy, q_t iia, q_t iib);
		q_t ca, cb;
		ca = fcross(rax, ray, dx, dy);
		cb = fcross(rbx, rby, dx, dy);
		return fadd(fadd(tot, fmul(fmul(ca, ca), iia)), fmul(fmul(cb, cb), iib));
	endfunction

	task automatic push_impulse(int i, q_t jx, q_t jy, q_t rx, q_t ry);
		m_vx[i] = fadd(m_vx[i], fmul(jx, m_im[i]));
		m_vy[i] = fadd(m_vy[i], fmul(jy, m_im[i]));
		m_av[i] = fadd(m_av[i], fmul(fcross(rx, ry, jx, jy), m_ii[i]));
	endtask

	task automatic resolve_contact(int a, int b, cmd_t c);
		q_t tot, ca, cb, e, f, rax, ray, rbx, rby, vax, vay, vbx, vby, rvx, rvy;
		q_t vn, vt, jn, jt, jx, jy, tx, ty;
		if (m_im[a] == 0 && m_im[b] == 0) return;
		tot = fadd(m_im[a], m_im[b]);
		if (tot == 0) return;
		// separation along the normal
		ca = fdiv(fmul(c.s1, m_im[a]), tot);
		cb = fdiv(fmul(c.s1, m_im[b]), tot);
		m_px[a] = fsub(m_px[a], fmul(c.v3x, ca));
		m_py[a] = fsub(m_py[a], fmul(c.v3y, ca));
		m_px[b] = fadd(m_px[b], fmul(c.v3x, cb));
		m_py[b] = fadd(m_py[b], fmul(c.v3y, cb));
		e = 32'(m_re[a] < m_re[b] ? m_re[a] : m_re[b]);
		f = 32'(m_fr[a] < m_fr[b] ? m_fr[a] : m_fr[b]);
		rax = fsub(c.v2x, m_px[a]);
		ray = fsub(c.v2y, m_py[a]);
		rbx = fsub(c.v1x, m_px[b]);
		rby = fsub(c.v1y, m_py[b]);
		vax = fadd(m_vx[a], fneg(fmul(m_av[a], ray)));
		vay = fadd(m_vy[a], fmul(m_av[a], rax));
		vbx = fadd(m_vx[b], fneg(fmul(m_av[b], rby)));
		vby = fadd(m_vy[b], fmul(m_av[b], rbx));
		rvx = fsub(vax, vbx);
		rvy = fsub(vay, vby);
		// normal and tangential impulses
		vn = fadd(fmul(rvx, c.v3x), fmul(rvy, c.v3y));
		jn = fdiv(fmul(fneg(fadd(ONE_Q, e)), vn),
			eff_mass(tot, rax, ray, rbx, rby, c.v3x, c.v3y, m_ii[a], m_ii[b]));
		tx = c.v3y;
		ty = fneg(c.v3x);
		vt = fadd(fmul(rvx, tx), fmul(rvy, ty));
		jt = fdiv(fmul(f, fneg(vt)),
			eff_mass(tot, rax, ray, rbx, rby, tx, ty, m_ii[a], m_ii[b]));
		jx = fadd(fmul(c.v3x, jn), fmul(tx, jt));
		jy = fadd(fmul(c.v3y, jn), fmul(ty, jt));
		push_impulse(a, jx, jy, rax, ray);
		push_impulse(b, fneg(jx), fneg(jy), rbx, rby);
	endtask

	function automatic report_t body_report(int i, bit fin);
		report_t r;
		r.idx = 6'(i); r.px = m_px[i]; r.py = m_py[i];
		r.vx = m_vx[i]; r.vy = m_vy[i]; r.av = m_av[i]; r.lst = fin;
		return r;
	endfunction

	// advance the table model for an accepted item, queue its reports
	task automatic predict_item(cmd_t c);
		int a, b;
		a = int'(c.ia); b = int'(c.ib);
		case (c.op)
			crir_pkg::OP_WRITE: begin
				m_px[a] = c.v1x; m_py[a] = c.v1y; m_vx[a] = c.v2x; m_vy[a] = c.v2y;
				m_av[a] = c.v3x; m_im[a] = c.v3y; m_ii[a] = c.s1;
				m_re[a] = c.s2; m_fr[a] = c.s3; written[a] = 1;
			end
			crir_pkg::OP_RESOLVE: begin
				resolve_contact(a, b, c);
				pending_reports.push_back(body_report(a, 0));
				pending_reports.push_back(body_report(b, 1));
			end
			crir_pkg::OP_READ: pending_reports.push_back(body_report(a, 1));
			default: ;
		endcase
	endtask

	// drive one item and wait for acceptance; valid drops only while idling
	task automatic send_item(cmd_t c);
		while (!no_idle && $urandom_range(99) < 31) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; op <= c.op; first_index <= c.ia; second_index <= c.ib;
		vec_one_x <= c.v1x; vec_one_y <= c.v1y; vec_two_x <= c.v2x; vec_two_y <= c.v2y;
		vec_three_x <= c.v3x; vec_three_y <= c.v3y; scalar_one <= c.s1;
		scalar_two <= c.s2; scalar_three <= c.s3;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(c);
	endtask

	function automatic q_t rnd32();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(131072)) - 65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t body_cmd(int i);
		cmd_t c;
		c.op = crir_pkg::OP_WRITE; c.ia = 6'(i); c.ib = 6'($urandom);
		c.v1x = rnd32(); c.v1y = rnd32(); c.v2x = rnd32(); c.v2y = rnd32();
		c.v3x = rnd32(); c.s1 = rnd32();
		// static bodies now and then
		c.v3y = ($urandom_range(5) == 0) ? 0 : rnd32();
		c.s2 = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
		c.s3 = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
		return c;
	endfunction

	function automatic int pick_written();
		int i;
		do i = $urandom_range(63); while (!written[i]);
		return i;
	endfunction

	function automatic cmd_t contact_cmd();
		cmd_t c;
		c = body_cmd(0);
		c.op = crir_pkg::OP_RESOLVE; c.ia = 6'(pick_written());
		c.ib = ($urandom_range(15) == 0) ? c.ia : 6'(pick_written());
		c.v3y = rnd32();
		c.s2 = 17'($urandom); c.s3 = 17'($urandom);
		return c;
	endfunction

	// receiver with random stalls and one long hold-off
	initial begin
		report_t exp_r;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			out_ready <= hold_off ? 0 : (no_idle || $urandom_range(99) >= 31);
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					$display("%0t: unexpected report idx %0d", $time, body_index);
					errors++;
				end else begin
					exp_r = pending_reports.pop_front();
					if (body_index !== exp_r.idx || pos_x !== exp_r.px || pos_y !== exp_r.py ||
						vel_x !== exp_r.vx || vel_y !== exp_r.vy || ang_vel !== exp_r.av ||
						last !== exp_r.lst) begin
						$display("%0t: expected %0d %h %h %h %h %h %b actual %0d %h %h %h %h %h %b",
							$time, exp_r.idx, exp_r.px, exp_r.py, exp_r.vx, exp_r.vy, exp_r.av,
							exp_r.lst, body_index, pos_x, pos_y, vel_x, vel_y, ang_vel, last);
						errors++;
					end
				end
			end
		end
	end

	cmd_t directed[$];

	initial begin
		cmd_t c;
		int n, waitc;
		report_t r;
		in_valid = 0; op = 0; first_index = 0; second_index = 0;
		vec_one_x = 0; vec_one_y = 0; vec_two_x = 0; vec_two_y = 0;
		vec_three_x = 0; vec_three_y = 0; scalar_one = 0; scalar_two = 0; scalar_three = 0;
		foreach (written[i]) written[i] = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, static pair, zero total, same body, op 3, reads
		c = '{crir_pkg::OP_WRITE, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 17'h1ffff, 17'h1ffff};
		directed.push_back(c);
		c = '{crir_pkg::OP_WRITE, 63, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 0, 0};
		directed.push_back(c);
		c = '{crir_pkg::OP_RESOLVE, 0, 63, 0, 0, 0, 0, ONE_Q, 0, ONE_Q, 0, 0};
		directed.push_back(c);
		c = '{crir_pkg::OP_WRITE, 1, 0, 0, 0, 0, 0, 0, ONE_Q, ONE_Q, 65536, 65536};
		directed.push_back(c);
		c = '{crir_pkg::OP_WRITE, 2, 0, 0, 0, 0, 0, 0, -ONE_Q, ONE_Q, 32768, 0};
		directed.push_back(c);
		c = '{crir_pkg::OP_RESOLVE, 1, 2, 0, 0, 0, 0, ONE_Q, 0, ONE_Q, 0, 0};
		directed.push_back(c);
		c = '{crir_pkg::OP_WRITE, 3, 0, ONE_Q, 0, -ONE_Q, ONE_Q, ONE_Q, 2 * ONE_Q, ONE_Q,
			65536, 65536};
		directed.push_back(c);
		c = '{crir_pkg::OP_WRITE, 4, 0, -ONE_Q, 0, ONE_Q, 0, -ONE_Q, 32768, 0, 16384, 40000};
		directed.push_back(c);
		c = '{crir_pkg::OP_RESOLVE, 3, 4, 0, 0, 0, 0, ONE_Q, 0, 32768, 0, 0};
		directed.push_back(c);
		c = '{crir_pkg::OP_RESOLVE, 3, 3, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 0, ONE_Q, 32'sh7fffffff, 0, 0};
		directed.push_back(c);
		c = '{crir_pkg::OP_RESOLVE, 63, 0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 17'h1ffff, 17'h1ffff};
		directed.push_back(c);
		c = '{crir_pkg::OP_NOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		directed.push_back(c);
		c = '{crir_pkg::OP_READ, 63, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		directed.push_back(c);
		c = '{crir_pkg::OP_READ, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		directed.push_back(c);
		foreach (directed[i]) begin
			send_item(directed[i]);
			// typed-in check: the static pair leaves body 63 unchanged
			if (i == 2) begin
				r = pending_reports[pending_reports.size() - 1];
				if (r.px !== 32'sh80000000 || r.av !== 32'sh80000000 || r.idx !== 63) begin
					$display("%0t: static pair expected 63 %h %h actual %0d %h %h", $time,
						32'sh80000000, 32'sh80000000, r.idx, r.px, r.av);
					errors++;
				end
			end
		end

		// fill the table so every entry is readable
		for (int i = 0; i < 64; i++) send_item(body_cmd(i));

		// long receiver hold-off while items keep coming
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int k = 0; k < 6; k++) send_item(contact_cmd());
				in_valid <= 0;
			end
		join

		// sender pause until all reports are back
		while (pending_reports.size() != 0) @(posedge clk);

		for (n = 0; n < 1270; n++) begin
			if (n == 300) no_idle = 1;
			if (n == 500) no_idle = 0;
			case ($urandom_range(9))
				0, 1: send_item(body_cmd($urandom_range(63)));
				2, 3: begin
					c = contact_cmd();
					c.op = crir_pkg::OP_READ;
					send_item(c);
				end
				4: begin
					c = body_cmd(0);
					c.op = crir_pkg::OP_NOP;
					send_item(c);
				end
				default: send_item(contact_cmd());
			endcase
		end
		in_valid <= 0;

		waitc = 0;
		while (pending_reports.size() != 0 && waitc < 200000) begin
			@(posedge clk);
			waitc++;
		end
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_reports.size() == 0)
			$display("tb_contact_impulse_resolver_unit: clean");
		else
			$display("tb_contact_impulse_resolver_unit: errors");
		$finish;
	end
endmodule

FILE: sim.f
rtl/crir_pkg.sv
rtl/crir_ram.sv
rtl/crir_div.sv
rtl/contact_impulse_resolver_unit.sv
bench/tb_contact_impulse_resolver_unit.sv
